@@ rtl/sic_pkg.sv @@
// Package with the beat types, kind codes and default sizes of the segment classifier.
`default_nettype none
package sic_pkg;

  localparam int DEF_COORD_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int FIELD_W        = 16;
  localparam int POS_W          = 32;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_PROPER  = 2'd1;
  localparam logic [1:0] KIND_POINT   = 2'd2;
  localparam logic [1:0] KIND_OVERLAP = 2'd3;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_start_x;
    logic signed [FIELD_W-1:0] a_start_y;
    logic signed [FIELD_W-1:0] a_end_x;
    logic signed [FIELD_W-1:0] a_end_y;
    logic signed [FIELD_W-1:0] b_start_x;
    logic signed [FIELD_W-1:0] b_start_y;
    logic signed [FIELD_W-1:0] b_end_x;
    logic signed [FIELD_W-1:0] b_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic        [1:0]       kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } seg_result_t;

endpackage
`default_nettype wire

@@ rtl/segment_intersection_classifier.sv @@
// Top level of the pipelined two-segment intersection classifier.
//
//   channel | direction | handshake           | payload
//   seg     | in        | seg_valid/seg_stall | seg_pair_t (segments A and B)
//   res     | out       | res_valid/res_stall | seg_result_t (kind, pos_x, pos_y)
//
// One beat enters per cycle while the pipeline is not stalled.
// Most of the pipeline is the restoring divider, one quotient bit per stage.
// Reset is synchronous and empties every pipeline stage.
// A stalled output beat freezes the whole pipeline, and seg_stall follows it.
`default_nettype none
module segment_intersection_classifier import sic_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        seg_valid,
  output logic             seg_stall,
  input  wire seg_pair_t   seg,
  output logic             res_valid,
  input  wire logic        res_stall,
  output seg_result_t      res
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = 2 * CB + 4;
  localparam int NW   = 2 * CB + 3;
  localparam int QW   = CB + FRAC_BITS;
  localparam int MW   = CB + NW;
  localparam int DVW  = MW + FRAC_BITS;
  localparam int OSW  = CB + FRAC_BITS + 3;

  logic adv;
  assign adv       = !(res_valid && res_stall);
  assign seg_stall = !adv;

  // Stage 1: coordinates, differences and the box test.
  logic signed [CB-1:0] ax0_c, ay0_c, ax1_c, ay1_c, bx0_c, by0_c, bx1_c, by1_c;
  logic                 box_c;
  assign ax0_c = CB'(seg.a_start_x);
  assign ay0_c = CB'(seg.a_start_y);
  assign ax1_c = CB'(seg.a_end_x);
  assign ay1_c = CB'(seg.a_end_y);
  assign bx0_c = CB'(seg.b_start_x);
  assign by0_c = CB'(seg.b_start_y);
  assign bx1_c = CB'(seg.b_end_x);
  assign by1_c = CB'(seg.b_end_y);

  always_comb begin
    logic signed [CB-1:0] amx, amnx, bmx, bmnx, amy, amny, bmy, bmny;
    amx  = (ax0_c > ax1_c) ? ax0_c : ax1_c;
    amnx = (ax0_c < ax1_c) ? ax0_c : ax1_c;
    bmx  = (bx0_c > bx1_c) ? bx0_c : bx1_c;
    bmnx = (bx0_c < bx1_c) ? bx0_c : bx1_c;
    amy  = (ay0_c > ay1_c) ? ay0_c : ay1_c;
    amny = (ay0_c < ay1_c) ? ay0_c : ay1_c;
    bmy  = (by0_c > by1_c) ? by0_c : by1_c;
    bmny = (by0_c < by1_c) ? by0_c : by1_c;
    box_c = !(amx < bmnx || bmx < amnx || amy < bmny || bmy < amny);
  end

  logic                 v1, box1;
  logic signed [CB-1:0] ax1r, ay1r;
  logic signed [DW-1:0] rx1, ry1, sx1, sy1, qx1, qy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box1 <= box_c;
      ax1r <= ax0_c;
      ay1r <= ay0_c;
      rx1  <= DW'(ax1_c) - DW'(ax0_c);
      ry1  <= DW'(ay1_c) - DW'(ay0_c);
      sx1  <= DW'(bx1_c) - DW'(bx0_c);
      sy1  <= DW'(by1_c) - DW'(by0_c);
      qx1  <= DW'(bx0_c) - DW'(ax0_c);
      qy1  <= DW'(by0_c) - DW'(ay0_c);
    end
  end

  // Stage 2: products.
  logic                 v2, box2;
  logic signed [CB-1:0] ax2, ay2;
  logic signed [DW-1:0] rx2, ry2;
  logic signed [PW-1:0] p_den_a, p_den_b, p_tn_a, p_tn_b, p_un_a, p_un_b;
  logic signed [PW-1:0] p_rr_a, p_rr_b, p_t0_a, p_t0_b, p_ds_a, p_ds_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box2    <= box1;
      ax2     <= ax1r;
      ay2     <= ay1r;
      rx2     <= rx1;
      ry2     <= ry1;
      p_den_a <= PW'(rx1) * PW'(sy1);
      p_den_b <= PW'(ry1) * PW'(sx1);
      p_tn_a  <= PW'(qx1) * PW'(sy1);
      p_tn_b  <= PW'(qy1) * PW'(sx1);
      p_un_a  <= PW'(qx1) * PW'(ry1);
      p_un_b  <= PW'(qy1) * PW'(rx1);
      p_rr_a  <= PW'(rx1) * PW'(rx1);
      p_rr_b  <= PW'(ry1) * PW'(ry1);
      p_t0_a  <= PW'(qx1) * PW'(rx1);
      p_t0_b  <= PW'(qy1) * PW'(ry1);
      p_ds_a  <= PW'(sx1) * PW'(rx1);
      p_ds_b  <= PW'(sy1) * PW'(ry1);
    end
  end

  // Stage 3: cross and dot products.
  logic                 v3, box3;
  logic signed [CB-1:0] ax3, ay3;
  logic signed [DW-1:0] rx3, ry3;
  logic signed [SW-1:0] den3, tn3, un3, rr3, t03, t13;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box3 <= box2;
      ax3  <= ax2;
      ay3  <= ay2;
      rx3  <= rx2;
      ry3  <= ry2;
      den3 <= SW'(p_den_a) - SW'(p_den_b);
      tn3  <= SW'(p_tn_a) - SW'(p_tn_b);
      un3  <= SW'(p_un_a) - SW'(p_un_b);
      rr3  <= SW'(p_rr_a) + SW'(p_rr_b);
      t03  <= SW'(p_t0_a) + SW'(p_t0_b);
      t13  <= SW'(p_t0_a) + SW'(p_t0_b) + SW'(p_ds_a) + SW'(p_ds_b);
    end
  end

  // Stage 4: classification and choice of the ratio.
  logic [1:0]    kind_c;
  logic [NW-1:0] num_c, dnm_c;

  always_comb begin
    logic signed [SW-1:0] d, tn, un, lo, hi, mn, mxv;
    logic                 inner;
    kind_c = KIND_NONE;
    num_c  = '0;
    dnm_c  = '0;
    d  = (den3 < 0) ? -den3 : den3;
    tn = (den3 < 0) ? -tn3 : tn3;
    un = (den3 < 0) ? -un3 : un3;
    mn  = (t03 < t13) ? t03 : t13;
    mxv = (t03 > t13) ? t03 : t13;
    lo  = (mn > 0) ? mn : '0;
    hi  = (rr3 < mxv) ? rr3 : mxv;
    inner = tn > 0 && tn < d && un > 0 && un < d;
    if (!box3) begin
      kind_c = KIND_NONE;
    end else if (den3 != 0) begin
      if (!(tn < 0 || tn > d || un < 0 || un > d)) begin
        kind_c = inner ? KIND_PROPER : KIND_POINT;
        num_c  = NW'(tn);
        dnm_c  = NW'(d);
      end
    end else if (un3 == 0 && rr3 > 0 && hi >= lo) begin
      kind_c = (hi > lo) ? KIND_OVERLAP : KIND_POINT;
      num_c  = NW'(lo + hi);
      dnm_c  = NW'(rr3 <<< 1);
    end
  end

  logic                 v4, negx4, negy4;
  logic [1:0]           kind4;
  logic signed [CB-1:0] ax4, ay4;
  logic [CB-1:0]        magx4, magy4;
  logic [NW-1:0]        num4, dnm4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind4 <= kind_c;
      num4  <= num_c;
      dnm4  <= dnm_c;
      ax4   <= ax3;
      ay4   <= ay3;
      negx4 <= rx3 < 0;
      negy4 <= ry3 < 0;
      magx4 <= CB'((rx3 < 0) ? -rx3 : rx3);
      magy4 <= CB'((ry3 < 0) ? -ry3 : ry3);
    end
  end

  // Stage 5 and the divider: quotient bits one per stage.
  logic [MW-1:0]  prodx, prody;
  logic [DVW-1:0] dvdx, dvdy;
  assign prodx = MW'(magx4) * MW'(num4);
  assign prody = MW'(magy4) * MW'(num4);
  assign dvdx  = DVW'(prodx) << FRAC_BITS;
  assign dvdy  = DVW'(prody) << FRAC_BITS;

  logic                 vd   [QW+1];
  logic [1:0]           kd   [QW+1];
  logic signed [CB-1:0] axd  [QW+1];
  logic signed [CB-1:0] ayd  [QW+1];
  logic                 nxd  [QW+1];
  logic                 nyd  [QW+1];
  logic [NW-1:0]        dnd  [QW+1];
  logic [NW-1:0]        remx [QW+1];
  logic [NW-1:0]        remy [QW+1];
  logic [QW-1:0]        shx  [QW+1];
  logic [QW-1:0]        shy  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (adv) begin
      vd[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kd[0]   <= kind4;
      axd[0]  <= ax4;
      ayd[0]  <= ay4;
      nxd[0]  <= negx4;
      nyd[0]  <= negy4;
      dnd[0]  <= dnm4;
      remx[0] <= dvdx[DVW-1:QW];
      remy[0] <= dvdy[DVW-1:QW];
      shx[0]  <= dvdx[QW-1:0];
      shy[0]  <= dvdy[QW-1:0];
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [NW:0] trx, try_;
    logic        gex, gey;
    assign trx  = {remx[i], shx[i][QW-1]};
    assign try_ = {remy[i], shy[i][QW-1]};
    assign gex  = trx >= {1'b0, dnd[i]};
    assign gey  = try_ >= {1'b0, dnd[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i+1] <= 1'b0;
      end else if (adv) begin
        vd[i+1] <= vd[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        kd[i+1]   <= kd[i];
        axd[i+1]  <= axd[i];
        ayd[i+1]  <= ayd[i];
        nxd[i+1]  <= nxd[i];
        nyd[i+1]  <= nyd[i];
        dnd[i+1]  <= dnd[i];
        remx[i+1] <= NW'(gex ? trx - {1'b0, dnd[i]} : trx);
        remy[i+1] <= NW'(gey ? try_ - {1'b0, dnd[i]} : try_);
        shx[i+1]  <= {shx[i][QW-2:0], gex};
        shy[i+1]  <= {shy[i][QW-2:0], gey};
      end
    end
  end

  // Rounding stage.
  logic                 vr;
  logic [1:0]           kr;
  logic signed [CB-1:0] axr, ayr;
  logic signed [OSW-1:0] offx, offy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (adv) begin
      vr <= vd[QW];
    end
  end

  always_comb begin
    logic [QW:0] qx, qy;
    qx = {1'b0, shx[QW]} + (QW+1)'(remx[QW] >= dnd[QW] - remx[QW]);
    qy = {1'b0, shy[QW]} + (QW+1)'(remy[QW] >= dnd[QW] - remy[QW]);
    offx = nxd[QW] ? -OSW'(qx) : OSW'(qx);
    offy = nyd[QW] ? -OSW'(qy) : OSW'(qy);
  end

  logic signed [OSW-1:0] offxr, offyr;

  always_ff @(posedge clk) begin
    if (adv) begin
      kr    <= kd[QW];
      axr   <= axd[QW];
      ayr   <= ayd[QW];
      offxr <= offx;
      offyr <= offy;
    end
  end

  // Output register.
  logic signed [OSW-1:0] sumx, sumy;
  assign sumx = (OSW'(axr) <<< FRAC_BITS) + offxr;
  assign sumy = (OSW'(ayr) <<< FRAC_BITS) + offyr;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.kind  <= kr;
      res.pos_x <= (kr == KIND_NONE) ? '0 : POS_W'(sumx);
      res.pos_y <= (kr == KIND_NONE) ? '0 : POS_W'(sumy);
    end
  end

endmodule
`default_nettype wire

@@ rtl/sic_checker.sv @@
// Port checker for the segment classifier and its bind statement.
`default_nettype none
module sic_checker import sic_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        seg_valid,
  input wire logic        seg_stall,
  input wire seg_pair_t   seg,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire seg_result_t res
);

  // A result beat with kind none carries a zero position.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_NONE |-> res.pos_x == 0 && res.pos_y == 0)
    else $error("none result with nonzero position");

  // The input side only waits while an output beat is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    seg_stall |-> res_valid && res_stall)
    else $error("input stalled without an output stall");

  // Reset leaves no result beat behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result beat right after reset");

  // A held output beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result beat changed");

  // A held input beat keeps its payload.
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_stall |=> seg_valid && $stable(seg))
    else $error("stalled input beat changed");

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (
  .clk       (clk),
  .rst       (rst),
  .seg_valid (seg_valid),
  .seg_stall (seg_stall),
  .seg       (seg),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);
`default_nettype wire

@@ tb/tb_segment_intersection_classifier.sv @@
// Testbench for the segment intersection classifier: random and directed pairs, checked per beat.
`default_nettype none
module tb_segment_intersection_classifier;
  import sic_pkg::*;

  localparam int LATENCY = DEF_COORD_BITS + DEF_FRAC_BITS + 7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seg_valid = 1'b0;
  logic        seg_stall;
  seg_pair_t   seg = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  seg_result_t res;

  seg_pair_t   pending_pairs[$];
  seg_result_t expected_results[$];
  int          error_count = 0;
  int          checked_count = 0;
  int          kind_seen[4] = '{0, 0, 0, 0};
  int          send_gap = 0;
  int          stall_left = 0;
  bit          hold_sender = 1'b0;
  bit          seg_taken = 1'b0;

  segment_intersection_classifier i_dut (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  // Scales comp by num/den in fixed point, rounding the magnitude half up.
  function automatic longint scaled_offset(longint comp, longint num, longint den);
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] r;
    longint       mag;
    mag = comp < 0 ? -comp : comp;
    prod = (128'(mag) * 128'(num)) << DEF_FRAC_BITS;
    q = prod / 128'(den);
    r = prod % 128'(den);
    if (r >= 128'(den) - r) q = q + 1;
    return comp < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic seg_result_t place_point(logic [1:0] k, longint ox, longint oy,
                                              longint px, longint py);
    seg_result_t o;
    o.kind = k;
    o.pos_x = 32'((ox <<< DEF_FRAC_BITS) + px);
    o.pos_y = 32'((oy <<< DEF_FRAC_BITS) + py);
    return o;
  endfunction

  function automatic seg_result_t classify_pair(seg_pair_t p);
    seg_result_t o;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint rx, ry, sx, sy, qx, qy, den, tn, un, rr, t0, t1, lo, hi;
    o = '0;
    o.kind = KIND_NONE;
    ax0 = p.a_start_x; ay0 = p.a_start_y; ax1 = p.a_end_x; ay1 = p.a_end_y;
    bx0 = p.b_start_x; by0 = p.b_start_y; bx1 = p.b_end_x; by1 = p.b_end_y;
    if (lmax(ax0, ax1) < lmin(bx0, bx1) || lmax(bx0, bx1) < lmin(ax0, ax1) ||
        lmax(ay0, ay1) < lmin(by0, by1) || lmax(by0, by1) < lmin(ay0, ay1))
      return o;
    rx = ax1 - ax0; ry = ay1 - ay0;
    sx = bx1 - bx0; sy = by1 - by0;
    qx = bx0 - ax0; qy = by0 - ay0;
    den = rx * sy - ry * sx;
    if (den != 0) begin
      tn = qx * sy - qy * sx;
      un = qx * ry - qy * rx;
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if (tn < 0 || tn > den || un < 0 || un > den) return o;
      return place_point((tn > 0 && tn < den && un > 0 && un < den) ? KIND_PROPER : KIND_POINT,
                         ax0, ay0, scaled_offset(rx, tn, den), scaled_offset(ry, tn, den));
    end
    if (qx * ry - qy * rx != 0) return o;
    rr = rx * rx + ry * ry;
    if (rr <= 0) return o;
    t0 = qx * rx + qy * ry;
    t1 = t0 + sx * rx + sy * ry;
    lo = lmax(0, lmin(t0, t1));
    hi = lmin(rr, lmax(t0, t1));
    if (hi < lo) return o;
    return place_point(hi > lo ? KIND_OVERLAP : KIND_POINT, ax0, ay0,
                       scaled_offset(rx, lo + hi, 2 * rr), scaled_offset(ry, lo + hi, 2 * rr));
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s after %0d beats: got %0d, expected %0d",
             what, checked_count, got, want);
    error_count++;
  endtask

  task automatic queue_pair(longint ax0, longint ay0, longint ax1, longint ay1,
                            longint bx0, longint by0, longint bx1, longint by1);
    seg_pair_t p;
    p.a_start_x = 16'(ax0); p.a_start_y = 16'(ay0);
    p.a_end_x = 16'(ax1);   p.a_end_y = 16'(ay1);
    p.b_start_x = 16'(bx0); p.b_start_y = 16'(by0);
    p.b_end_x = 16'(bx1);   p.b_end_y = 16'(by1);
    pending_pairs.insert(pending_pairs.size(), p);
  endtask

  function automatic longint rand_coord(int span);
    if (span == 0) return longint'(signed'(16'($urandom)));
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Input side: beats change at the falling edge, acceptance is seen at the rising edge.
  always @(posedge clk) begin
    seg_taken <= !rst && seg_valid && !seg_stall;
    if (!rst && seg_valid && !seg_stall) begin
      expected_results.insert(expected_results.size(), classify_pair(seg));
      void'(pending_pairs.pop_front());
      send_gap <= pick_gap();
    end else if (!seg_valid && send_gap > 0) begin
      send_gap <= send_gap - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!seg_valid || seg_taken)) begin
      if (pending_pairs.size() > 0 && send_gap == 0 && !hold_sender) begin
        seg_valid <= 1'b1;
        seg <= pending_pairs[0];
      end else begin
        seg_valid <= 1'b0;
        seg <= seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
      end
    end
  end

  always @(posedge clk) begin
    seg_result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result beat, kind %0d", res.kind);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res.kind !== want.kind) report_mismatch("kind", res.kind, want.kind);
        if (res.pos_x !== want.pos_x) report_mismatch("pos_x", res.pos_x, want.pos_x);
        if (res.pos_y !== want.pos_y) report_mismatch("pos_y", res.pos_y, want.pos_y);
        kind_seen[want.kind]++;
      end
      checked_count++;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      res_stall <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      res_stall <= 1'b0;
    end
  end

  initial begin
    int    n;
    int    span;
    longint ax0, ay0, ax1, ay1, t, u, dx, dy;
    queue_pair(0, 0, 10, 10, 0, 10, 10, 0);
    queue_pair(0, 0, 10, 0, 5, 0, 5, 7);
    queue_pair(0, 0, 10, 0, 20, 0, 30, 0);
    queue_pair(0, 0, 10, 0, 3, 0, 30, 0);
    queue_pair(0, 0, 10, 0, 10, 0, 30, 0);
    queue_pair(0, 0, 10, 0, 5, 1, 15, 1);
    queue_pair(3, 3, 3, 3, 3, 3, 5, 5);
    queue_pair(0, 0, 8, 8, 4, 4, 4, 4);
    queue_pair(0, 0, 8, 8, 9, 9, 9, 9);
    queue_pair(0, 0, 4, 4, 0, 3, 3, 0);
    queue_pair(0, 0, 10, 10, 5, 4, 9, 0);
    queue_pair(0, 0, 3, 0, 0, 1, 1, 2);
    queue_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    queue_pair(-32768, 0, 32767, 0, 32767, 0, -32768, 0);
    queue_pair(32767, 32767, -32768, -32768, 0, 0, 1, 1);
    queue_pair(-32768, -32768, 32767, -32767, -32768, -32768, 32767, 32767);
    queue_pair(0, 0, 3, 0, 1, 0, 2, 0);
    queue_pair(0, 0, 1, 3, 0, 1, 1, 0);
    queue_pair(0, 0, -7, 3, -7, 0, 0, 3);
    queue_pair(5, 5, 0, 0, 2, 2, -4, -4);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && expected_results.size() == 0);
    hold_sender = 1'b1;
    repeat (LATENCY + 4) @(posedge clk);
    hold_sender = 1'b0;
    for (n = 0; n < 1250; n++) begin
      span = $urandom_range(0, 3) == 0 ? 0 : ($urandom_range(0, 1) ? 20 : 2000);
      ax0 = rand_coord(span); ay0 = rand_coord(span);
      ax1 = rand_coord(span); ay1 = rand_coord(span);
      case ($urandom_range(0, 5))
        0: queue_pair(ax0, ay0, ax1, ay1, rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span));
        1, 2: begin
          // Segment B placed around a point of A, often crossing A.
          t = $urandom_range(0, 4);
          dx = ((ax1 - ax0) * t) / 4; dy = ((ay1 - ay0) * t) / 4;
          u = $urandom_range(1, 30);
          queue_pair(ax0, ay0, ax1, ay1, ax0 + dx - u, ay0 + dy + $urandom_range(0, 30),
                     ax0 + dx + $urandom_range(0, 30), ay0 + dy - u);
        end
        3: begin
          // B along the line of A, at a scaled position.
          dx = $urandom_range(0, 40) - 20; dy = $urandom_range(0, 40) - 20;
          t = $urandom_range(0, 12) - 4; u = $urandom_range(0, 12) - 4;
          queue_pair(ax0, ay0, ax0 + 4 * dx, ay0 + 4 * dy,
                     ax0 + t * dx, ay0 + t * dy, ax0 + u * dx, ay0 + u * dy);
        end
        4: queue_pair(ax0, ay0, ax1, ay1, ax1, ay1, rand_coord(span), rand_coord(span));
        default: queue_pair(ax0, ay0, ax0, ay0, ax0, ay0, ax1, ay1);
      endcase
    end
    wait (pending_pairs.size() == 0 && expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d result beats: none %0d, proper %0d, point %0d, overlap %0d",
             checked_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (error_count == 0) begin
      $display("tb_segment_intersection_classifier: clean");
    end else begin
      $display("tb_segment_intersection_classifier: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb_segment_intersection_classifier: errors");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/sic_pkg.sv
rtl/segment_intersection_classifier.sv
rtl/sic_checker.sv
tb/tb_segment_intersection_classifier.sv
